>>> hw/rtl/i2cmbe_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; every other file of the block but the interface file imports this package.
package i2cmbe_pkg;

	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int HALF_W      = 16;
	localparam int POLL_W      = 8;
	localparam int PHASE_W     = 4;
	localparam int BITCNT_W    = 4;
	localparam int BYTE_W      = 8;
	localparam int REQ_W       = 3;

	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);

	typedef enum logic [1:0] {
		REG_HALF_PERIOD = 2'd0,
		REG_ACK_TIMEOUT = 2'd1,
		REG_IGNORE_ACK  = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [REQ_W-1:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_WAIT  = 3'd5
	} cmd_kind_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_0 = 4'd0,
		PH_1 = 4'd1,
		PH_2 = 4'd2,
		PH_3 = 4'd3,
		PH_4 = 4'd4
	} phase_t;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(5);
	localparam logic [POLL_W-1:0] ACK_TIMEOUT_RST = POLL_W'(250);

	typedef struct packed {
		logic [HALF_W-1:0] half_period_ticks;
		logic [POLL_W-1:0] ack_timeout;
		logic              ignore_ack_mode;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [BYTE_W-1:0] data_byte;
		logic              send_nack;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		logic              scl_out;
		logic              sda_out;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
		logic              ack_seen;
		logic              ack_error;
	} result_t;

endpackage

>>> hw/rtl/i2cmbe_if.sv
// Request and result channel interfaces of the I2C master byte engine.
// Depends on nothing; payload widths follow the field definitions.
interface i2cmbe_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] data_byte;
	logic       send_nack;
	logic       sda_in;

	modport source (output valid, output req_type, output data_byte, output send_nack,
		output sda_in, input ready);
	modport sink (input valid, input req_type, input data_byte, input send_nack,
		input sda_in, output ready);
endinterface

interface i2cmbe_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_seen;
	logic       ack_error;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output done_res, output read_data, output ack_seen, output ack_error,
		input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input done_res, input read_data, input ack_seen, input ack_error,
		output ready);
endinterface

>>> hw/rtl/i2cmbe_cfg_regs.sv
// APB-style configuration registers: half period, ack timeout, ack-ignore mode.
// Depends on i2cmbe_pkg.
module i2cmbe_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [i2cmbe_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                  pready,
	output i2cmbe_pkg::cfg_t                      cfg
);
	import i2cmbe_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
			cfg_q.ack_timeout       <= ACK_TIMEOUT_RST;
			cfg_q.ignore_ack_mode   <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= pwdata[HALF_W-1:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= pwdata[POLL_W-1:0];
				REG_IGNORE_ACK:  cfg_q.ignore_ack_mode <= pwdata[0];
				REG_UNUSED:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_HALF_PERIOD: prdata = CFG_DATA_W'(cfg_q.half_period_ticks);
			REG_ACK_TIMEOUT: prdata = CFG_DATA_W'(cfg_q.ack_timeout);
			REG_IGNORE_ACK:  prdata = CFG_DATA_W'(cfg_q.ignore_ack_mode);
			REG_UNUSED:      prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/i2cmbe_core.sv
// Bus sequencer: command state, phase timing, shifter and result register.
// Depends on i2cmbe_pkg; fed by the input stage of the top level.
module i2cmbe_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire_s1,
	input  i2cmbe_pkg::item_t   item_s1,
	input  i2cmbe_pkg::cfg_t    cfg,
	output i2cmbe_pkg::result_t res_s2
);
	import i2cmbe_pkg::*;

	cmd_kind_t           kind_q, n_kind;
	phase_t              phase_q, n_phase;
	logic [BITCNT_W-1:0] bits_q, n_bits, bits_inc;
	logic [BYTE_W-1:0]   shift_q, n_shift;
	logic [HALF_W-1:0]   tick_q, n_tick, half;
	logic [HALF_W:0]     tick_inc;
	logic [POLL_W-1:0]   poll_q, n_poll;
	logic                nack_q, n_nack;
	logic                scl_q, n_scl, sda_q, n_sda;
	logic                mode_q, n_mode;
	logic [BYTE_W-1:0]   rd_q, n_rd;
	logic                ack_seen_q, n_ack_seen, ack_err_q, n_ack_err;
	logic                n_done;
	logic                is_cmd;
	result_t             n_res;

	assign half     = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
	assign tick_inc = {1'b0, tick_q} + (HALF_W+1)'(1);
	assign bits_inc = bits_q + BITCNT_W'(1);
	assign is_cmd   = (item_s1.req_type == CMD_START) || (item_s1.req_type == CMD_STOP)
		|| (item_s1.req_type == CMD_WRITE) || (item_s1.req_type == CMD_READ)
		|| (item_s1.req_type == CMD_WAIT);

	always_comb begin
		n_kind     = kind_q;
		n_phase    = phase_q;
		n_bits     = bits_q;
		n_shift    = shift_q;
		n_tick     = tick_q;
		n_poll     = poll_q;
		n_nack     = nack_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_mode     = mode_q;
		n_rd       = rd_q;
		n_ack_seen = ack_seen_q;
		n_ack_err  = ack_err_q;
		n_done     = 1'b0;
		if (kind_q == CMD_IDLE && is_cmd) begin
			n_kind  = cmd_kind_t'(item_s1.req_type);
			n_mode  = cfg.ignore_ack_mode;
			n_bits  = '0;
			n_poll  = '0;
			n_phase = PH_0;
			n_tick  = '0;
			n_scl   = 1'b1;
			n_sda   = 1'b1;
			unique case (cmd_kind_t'(item_s1.req_type))
				CMD_STOP: n_sda = 1'b0;
				CMD_WRITE: begin
					n_shift = item_s1.data_byte;
					n_scl   = !cfg.ignore_ack_mode;
					n_sda   = item_s1.data_byte[BYTE_W-1];
				end
				CMD_READ: begin
					n_shift = '0;
					n_nack  = item_s1.send_nack;
				end
				CMD_WAIT: n_scl = scl_q;
				default: ;
			endcase
		end else if (kind_q == CMD_WAIT && phase_q == PH_2) begin
			if (!item_s1.sda_in) begin
				n_phase = PH_3;
				n_scl   = 1'b0;
				n_sda   = 1'b1;
				n_tick  = '0;
			end else if (poll_q >= cfg.ack_timeout) begin
				n_phase = PH_4;
				n_scl   = 1'b1;
				n_sda   = 1'b0;
				n_tick  = '0;
			end else begin
				n_poll = poll_q + POLL_W'(1);
			end
		end else if (kind_q != CMD_IDLE) begin
			n_tick = tick_inc[HALF_W-1:0];
			if (tick_inc >= {1'b0, half}) begin
				n_tick = '0;
				unique case (kind_q)
					CMD_START: begin
						if (phase_q == PH_0) begin
							n_phase = PH_1;
							n_scl   = 1'b1;
							n_sda   = 1'b0;
						end else begin
							n_scl   = 1'b0;
							n_kind  = CMD_IDLE;
							n_phase = PH_0;
							n_done  = 1'b1;
						end
					end
					CMD_STOP: begin
						n_sda   = 1'b1;
						n_kind  = CMD_IDLE;
						n_phase = PH_0;
						n_done  = 1'b1;
					end
					CMD_WRITE: begin
						if (!mode_q) begin
							if (phase_q == PH_0) begin
								n_phase = PH_1;
								n_scl   = 1'b0;
							end else if (phase_q == PH_1) begin
								n_shift = {shift_q[BYTE_W-2:0], 1'b0};
								n_bits  = bits_inc;
								n_scl   = 1'b1;
								if (bits_inc >= BITS_PER_BYTE) begin
									n_phase = PH_2;
									n_sda   = 1'b1;
								end else begin
									n_phase = PH_0;
									n_sda   = shift_q[BYTE_W-2];
								end
							end else begin
								n_ack_seen = item_s1.sda_in;
								n_scl      = 1'b0;
								n_kind     = CMD_IDLE;
								n_phase    = PH_0;
								n_done     = 1'b1;
							end
						end else begin
							if (phase_q == PH_0) begin
								n_phase = PH_1;
								n_scl   = 1'b1;
							end else begin
								n_shift = {shift_q[BYTE_W-2:0], 1'b0};
								n_bits  = bits_inc;
								n_scl   = 1'b0;
								if (bits_inc >= BITS_PER_BYTE) begin
									n_kind  = CMD_IDLE;
									n_phase = PH_0;
									n_done  = 1'b1;
								end else begin
									n_phase = PH_0;
									n_sda   = shift_q[BYTE_W-2];
								end
							end
						end
					end
					CMD_READ: begin
						if (phase_q == PH_0) begin
							n_shift = {shift_q[BYTE_W-2:0], item_s1.sda_in};
							n_phase = PH_1;
							n_scl   = 1'b0;
							n_sda   = 1'b1;
						end else if (phase_q == PH_1) begin
							n_bits = bits_inc;
							n_scl  = 1'b1;
							if (bits_inc >= BITS_PER_BYTE) begin
								n_phase = PH_2;
								n_sda   = nack_q;
							end else begin
								n_phase = PH_0;
								n_sda   = 1'b1;
							end
						end else begin
							n_scl   = 1'b0;
							n_sda   = 1'b1;
							n_rd    = shift_q;
							n_kind  = CMD_IDLE;
							n_phase = PH_0;
							n_done  = 1'b1;
						end
					end
					CMD_WAIT: begin
						if (phase_q == PH_0) begin
							n_phase = PH_1;
							n_scl   = 1'b1;
							n_sda   = 1'b1;
						end else if (phase_q == PH_1) begin
							n_scl = !mode_q;
							n_sda = 1'b1;
							if (mode_q) begin
								n_phase = PH_3;
							end else begin
								n_phase = PH_2;
								n_poll  = '0;
							end
						end else if (phase_q == PH_3) begin
							n_ack_err = 1'b0;
							n_kind    = CMD_IDLE;
							n_phase   = PH_0;
							n_done    = 1'b1;
						end else if (phase_q == PH_4) begin
							n_sda     = 1'b1;
							n_ack_err = 1'b1;
							n_kind    = CMD_IDLE;
							n_phase   = PH_0;
							n_done    = 1'b1;
						end
					end
					default: begin
						n_kind  = CMD_IDLE;
						n_phase = PH_0;
						n_done  = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		n_res.scl_out   = n_scl;
		n_res.sda_out   = n_sda;
		n_res.busy_res  = (n_kind != CMD_IDLE);
		n_res.done_res  = n_done;
		n_res.read_data = n_rd;
		n_res.ack_seen  = n_ack_seen;
		n_res.ack_error = n_ack_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= CMD_IDLE;
			phase_q    <= PH_0;
			bits_q     <= '0;
			shift_q    <= '0;
			tick_q     <= '0;
			poll_q     <= '0;
			nack_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			mode_q     <= 1'b0;
			rd_q       <= '0;
			ack_seen_q <= 1'b0;
			ack_err_q  <= 1'b0;
			res_s2     <= '0;
		end else if (fire_s1) begin
			kind_q     <= n_kind;
			phase_q    <= n_phase;
			bits_q     <= n_bits;
			shift_q    <= n_shift;
			tick_q     <= n_tick;
			poll_q     <= n_poll;
			nack_q     <= n_nack;
			scl_q      <= n_scl;
			sda_q      <= n_sda;
			mode_q     <= n_mode;
			rd_q       <= n_rd;
			ack_seen_q <= n_ack_seen;
			ack_err_q  <= n_ack_err;
			res_s2     <= n_res;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == CMD_IDLE |-> phase_q == PH_0 && tick_q == '0)
		else $error("idle with phase or tick count left over");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_PER_BYTE && phase_q <= PH_4)
		else $error("bit count or phase out of range");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported while still busy");

	a_poll_lines: assert property (@(posedge clk) disable iff (!arst_n)
		kind_q == CMD_WAIT && phase_q == PH_2 |-> scl_q && sda_q && !mode_q)
		else $error("ack poll without both lines released");

endmodule

>>> hw/rtl/i2c_master_byte_engine_top.sv
// Channel  | Dir | Handshake     | Payload
// req      | in  | valid/ready   | req_type, data_byte, send_nack, sda_in
// res      | out | valid/ready   | scl_out, sda_out, busy_res, done_res, read_data,
//          |     |               | ack_seen, ack_error
// apb      | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
// Each request passes an input register and one step of the bus sequencer into
// the result register; one request per cycle sustained while res.ready is high.
// The single-entry input and result registers set the rate; a request is taken
// whenever the input register is empty or moves on in the same cycle.
// arst_n clears the sequencer to idle with both lines released; no clearing pass.
// A stalled result holds the sequencer and, one request later, the input.
module i2c_master_byte_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	i2cmbe_req_if.sink                        req,
	i2cmbe_res_if.source                      res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2cmbe_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [i2cmbe_pkg::CFG_DATA_W-1:0] prdata,
	output logic                              pready
);
	import i2cmbe_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    res_valid_q;
	logic    advance;
	logic    fire_s1;
	logic    req_fire;
	result_t res_s2;

	assign advance   = !res_valid_q || res.ready;
	assign fire_s1   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1.req_type  <= req.req_type;
			item_s1.data_byte <= req.data_byte;
			item_s1.send_nack <= req.send_nack;
			item_s1.sda_in    <= req.sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	i2cmbe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2cmbe_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire_s1 (fire_s1),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.res_s2  (res_s2)
	);

	assign res.valid     = res_valid_q;
	assign res.scl_out   = res_s2.scl_out;
	assign res.sda_out   = res_s2.sda_out;
	assign res.busy_res  = res_s2.busy_res;
	assign res.done_res  = res_s2.done_res;
	assign res.read_data = res_s2.read_data;
	assign res.ack_seen  = res_s2.ack_seen;
	assign res.ack_error = res_s2.ack_error;

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped a request under stall");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !valid_s1 |=> !res_valid_q)
		else $error("result shown without a request behind it");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && valid_s1 |-> fire_s1)
		else $error("request taken over an occupied input stage");

endmodule

>>> dv/tb_i2c_master_byte_engine_top.sv
// Self-checking testbench for the I2C master byte engine top level.
// Drives requests and APB writes, checks each result against a SystemVerilog
// prediction or a typed table row; uses i2cmbe_pkg, channel interfaces, RTL.
module tb_i2c_master_byte_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmbe_pkg::*;

	localparam logic [REQ_W-1:0] REQ_TICK = CMD_IDLE;
	localparam logic [REQ_W-1:0] REQ_BAD6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_BAD7 = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int N_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 250;

	localparam result_t IDLE_RES  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam result_t START_RES = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam cfg_t NO_CFG = '0;

	typedef enum int {SDA_RAND, SDA_ONES, SDA_LOW} sda_mode_t;

	typedef struct {
		bit                set_cfg;
		cfg_t              cfg;
		logic [REQ_W-1:0]  req;
		logic [BYTE_W-1:0] data;
		logic              nack;
		logic              sda;
		int                ticks;
		bit                typed;
		result_t           want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	i2cmbe_req_if req_ch();
	i2cmbe_res_if res_ch();

	i2c_master_byte_engine_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// bus engine prediction state
	cfg_t b_cfg;
	cmd_kind_t b_cmd;
	phase_t b_phase;
	logic [BITCNT_W-1:0] b_bits;
	logic [BYTE_W-1:0] b_shift;
	logic [HALF_W-1:0] b_ticks;
	logic [POLL_W-1:0] b_poll;
	logic b_nack, b_scl, b_sda, b_mode;
	logic [BYTE_W-1:0] b_rd;
	logic b_ack_seen, b_ack_err, b_done;

	result_t bus_levels_q[$];
	dir_row_t dir_tab[20];
	cfg_t phase_cfg[N_PHASES];

	int n_req, n_res, n_err, n_cfg, n_timeouts;
	int cmd_cnt[6];
	bit idling_on;
	bit hold_req;
	sda_mode_t sda_mode;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void bus_reset();
		b_cfg = '{HALF_PERIOD_RST, ACK_TIMEOUT_RST, 1'b0};
		b_cmd = CMD_IDLE;
		b_phase = PH_0;
		b_bits = '0;
		b_shift = '0;
		b_ticks = '0;
		b_poll = '0;
		b_nack = 1'b0;
		b_scl = 1'b1;
		b_sda = 1'b1;
		b_mode = 1'b0;
		b_rd = '0;
		b_ack_seen = 1'b0;
		b_ack_err = 1'b0;
		b_done = 1'b0;
	endfunction

	function automatic void enter_phase(input phase_t p, input logic scl, input logic sda);
		b_phase = p;
		b_scl = scl;
		b_sda = sda;
		b_ticks = '0;
	endfunction

	function automatic void close_cmd();
		b_cmd = CMD_IDLE;
		b_phase = PH_0;
		b_done = 1'b1;
	endfunction

	function automatic void bus_advance(input logic sda_in);
		logic [HALF_W-1:0] h;
		h = (b_cfg.half_period_ticks == '0) ? HALF_W'(1) : b_cfg.half_period_ticks;
		if (b_cmd == CMD_WAIT && b_phase == PH_2) begin
			if (!sda_in)
				enter_phase(PH_3, 1'b0, 1'b1);
			else if (b_poll >= b_cfg.ack_timeout)
				enter_phase(PH_4, 1'b1, 1'b0);
			else
				b_poll = b_poll + POLL_W'(1);
			return;
		end
		b_ticks = b_ticks + HALF_W'(1);
		if (b_ticks < h)
			return;
		b_ticks = '0;
		case (b_cmd)
			CMD_START: begin
				if (b_phase == PH_0)
					enter_phase(PH_1, 1'b1, 1'b0);
				else begin
					b_scl = 1'b0;
					close_cmd();
				end
			end
			CMD_STOP: begin
				b_sda = 1'b1;
				close_cmd();
			end
			CMD_WRITE: begin
				if (!b_mode) begin
					if (b_phase == PH_0)
						enter_phase(PH_1, 1'b0, b_sda);
					else if (b_phase == PH_1) begin
						b_shift = b_shift << 1;
						b_bits = b_bits + BITCNT_W'(1);
						if (b_bits >= BITS_PER_BYTE)
							enter_phase(PH_2, 1'b1, 1'b1);
						else
							enter_phase(PH_0, 1'b1, b_shift[7]);
					end else begin
						b_ack_seen = sda_in;
						b_scl = 1'b0;
						close_cmd();
					end
				end else begin
					if (b_phase == PH_0)
						enter_phase(PH_1, 1'b1, b_sda);
					else begin
						b_shift = b_shift << 1;
						b_bits = b_bits + BITCNT_W'(1);
						b_scl = 1'b0;
						if (b_bits >= BITS_PER_BYTE)
							close_cmd();
						else
							enter_phase(PH_0, 1'b0, b_shift[7]);
					end
				end
			end
			CMD_READ: begin
				if (b_phase == PH_0) begin
					b_shift = {b_shift[6:0], sda_in};
					enter_phase(PH_1, 1'b0, 1'b1);
				end else if (b_phase == PH_1) begin
					b_bits = b_bits + BITCNT_W'(1);
					if (b_bits >= BITS_PER_BYTE)
						enter_phase(PH_2, 1'b1, b_nack);
					else
						enter_phase(PH_0, 1'b1, 1'b1);
				end else begin
					b_scl = 1'b0;
					b_sda = 1'b1;
					b_rd = b_shift;
					close_cmd();
				end
			end
			CMD_WAIT: begin
				if (b_phase == PH_0)
					enter_phase(PH_1, 1'b1, 1'b1);
				else if (b_phase == PH_1) begin
					if (b_mode)
						enter_phase(PH_3, 1'b0, 1'b1);
					else begin
						enter_phase(PH_2, 1'b1, 1'b1);
						b_poll = '0;
					end
				end else if (b_phase == PH_3) begin
					b_ack_err = 1'b0;
					close_cmd();
				end else if (b_phase == PH_4) begin
					b_sda = 1'b1;
					b_ack_err = 1'b1;
					n_timeouts++;
					close_cmd();
				end
			end
			default: close_cmd();
		endcase
	endfunction

	function automatic result_t bus_step(input item_t it);
		result_t r;
		b_done = 1'b0;
		if (b_cmd == CMD_IDLE && it.req_type >= CMD_START && it.req_type <= CMD_WAIT) begin
			b_cmd = cmd_kind_t'(it.req_type);
			cmd_cnt[b_cmd]++;
			b_mode = b_cfg.ignore_ack_mode;
			b_bits = '0;
			b_poll = '0;
			case (b_cmd)
				CMD_START: enter_phase(PH_0, 1'b1, 1'b1);
				CMD_STOP:  enter_phase(PH_0, 1'b1, 1'b0);
				CMD_WRITE: begin
					b_shift = it.data_byte;
					enter_phase(PH_0, !b_mode, b_shift[7]);
				end
				CMD_READ: begin
					b_shift = '0;
					b_nack = it.send_nack;
					enter_phase(PH_0, 1'b1, 1'b1);
				end
				default: enter_phase(PH_0, b_scl, 1'b1);
			endcase
		end else if (b_cmd != CMD_IDLE) begin
			bus_advance(it.sda_in);
		end
		r.scl_out = b_scl;
		r.sda_out = b_sda;
		r.busy_res = (b_cmd != CMD_IDLE);
		r.done_res = b_done;
		r.read_data = b_rd;
		r.ack_seen = b_ack_seen;
		r.ack_error = b_ack_err;
		return r;
	endfunction

	task automatic offer_request(input item_t it, input bit typed, input result_t typed_res);
		result_t pr;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.req_type;
		req_ch.data_byte <= it.data_byte;
		req_ch.send_nack <= it.send_nack;
		req_ch.sda_in <= it.sda_in;
		do @(posedge clk); while (!req_ch.ready);
		pr = bus_step(it);
		bus_levels_q.push_back(typed ? typed_res : pr);
		n_req++;
	endtask

	task automatic offer_tick(input logic sda);
		item_t it;
		it.req_type = REQ_TICK;
		it.data_byte = BYTE_W'($urandom);
		it.send_nack = 1'($urandom);
		it.sda_in = sda;
		offer_request(it, 1'b0, IDLE_RES);
	endtask

	task automatic drain_levels();
		req_ch.valid <= 1'b0;
		while (bus_levels_q.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apply_cfg(input cfg_t c);
		drain_levels();
		apb_write(REG_HALF_PERIOD, CFG_DATA_W'(c.half_period_ticks));
		apb_write(REG_ACK_TIMEOUT, CFG_DATA_W'(c.ack_timeout));
		apb_write(REG_IGNORE_ACK, CFG_DATA_W'(c.ignore_ack_mode));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		b_cfg = c;
		n_cfg++;
	endtask

	task automatic run_random(input int phase_no);
		item_t it;
		int useful;
		int pick;
		useful = 0;
		while (useful < ITEMS_PER_PHASE) begin
			it.data_byte = BYTE_W'($urandom);
			it.send_nack = 1'($urandom);
			if (b_cmd == CMD_IDLE) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					it.req_type = REQ_TICK;
				else if (pick == 1)
					it.req_type = REQ_W'($urandom_range(REQ_BAD7, REQ_BAD6));
				else begin
					it.req_type = REQ_W'($urandom_range(CMD_WAIT, CMD_START));
					sda_mode = sda_mode_t'($urandom_range(SDA_LOW, SDA_RAND));
				end
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					it.req_type = REQ_W'($urandom_range(CMD_WAIT, CMD_START));
				else if (pick == 1)
					it.req_type = REQ_W'($urandom_range(REQ_BAD7, REQ_BAD6));
				else
					it.req_type = REQ_TICK;
			end
			case (sda_mode)
				SDA_ONES: it.sda_in = 1'b1;
				SDA_LOW:  it.sda_in = 1'b0;
				default:  it.sda_in = 1'($urandom);
			endcase
			if (b_cmd != CMD_IDLE || (it.req_type >= CMD_START && it.req_type <= CMD_WAIT))
				useful++;
			if (phase_no == 1 && useful == 100)
				hold_req = 1'b1;
			if (phase_no == 2 && useful == 150)
				drain_levels();
			offer_request(it, 1'b0, IDLE_RES);
		end
	endtask

	// result side: check and stall
	initial begin
		result_t got, want;
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.scl_out, res_ch.sda_out, res_ch.busy_res, res_ch.done_res,
					res_ch.read_data, res_ch.ack_seen, res_ch.ack_error};
				n_res++;
				if (bus_levels_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: result %0d arrived with nothing pending", n_res);
				end else begin
					want = bus_levels_q.pop_front();
					if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
						got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
						got.read_data !== want.read_data || got.ack_seen !== want.ack_seen ||
						got.ack_error !== want.ack_error) begin
						n_err++;
						if (n_err <= 10)
							$display("ERROR: result %0d want/got scl %b/%b sda %b/%b busy %b/%b %s",
								n_res, want.scl_out, got.scl_out, want.sda_out, got.sda_out,
								want.busy_res, got.busy_res,
								$sformatf("done %b/%b rd %h/%h ack %b/%b err %b/%b",
								want.done_res, got.done_res, want.read_data, got.read_data,
								want.ack_seen, got.ack_seen, want.ack_error, got.ack_error));
					end
				end
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no transfer for %0d cycles, %0d results pending", QUIET_LIMIT,
			bus_levels_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		item_t it;
		n_req = 0;
		n_res = 0;
		n_err = 0;
		n_cfg = 0;
		n_timeouts = 0;
		foreach (cmd_cnt[k])
			cmd_cnt[k] = 0;
		idling_on = 1'b1;
		hold_req = 1'b0;
		sda_mode = SDA_RAND;
		bus_reset();

		dir_tab = '{
			'{0, NO_CFG, REQ_TICK,  8'h00, 0, 0, 0,  1, IDLE_RES},
			'{0, NO_CFG, REQ_BAD6,  8'h00, 0, 0, 0,  1, IDLE_RES},
			'{0, NO_CFG, REQ_BAD7,  8'h00, 0, 0, 0,  1, IDLE_RES},
			'{0, NO_CFG, CMD_START, 8'h00, 0, 0, 10, 1, START_RES},
			'{0, NO_CFG, CMD_WAIT,  8'h00, 0, 0, 18, 0, IDLE_RES},
			'{1, '{16'd0, 8'd0, 1'b0}, CMD_WRITE, 8'hFF, 0, 0, 18, 0, IDLE_RES},
			'{0, NO_CFG, CMD_WRITE, 8'h00, 0, 1, 18, 0, IDLE_RES},
			'{0, NO_CFG, CMD_WRITE, 8'h5A, 0, 0, 3,  0, IDLE_RES},
			'{0, NO_CFG, CMD_READ,  8'h00, 1, 1, 16, 0, IDLE_RES},
			'{0, NO_CFG, CMD_READ,  8'h00, 0, 1, 18, 0, IDLE_RES},
			'{0, NO_CFG, CMD_READ,  8'hFF, 1, 0, 18, 0, IDLE_RES},
			'{0, NO_CFG, CMD_WAIT,  8'h00, 0, 1, 6,  0, IDLE_RES},
			'{0, NO_CFG, CMD_STOP,  8'h00, 0, 1, 3,  0, IDLE_RES},
			'{0, NO_CFG, CMD_WAIT,  8'h00, 0, 0, 6,  0, IDLE_RES},
			'{0, NO_CFG, CMD_STOP,  8'h00, 0, 0, 3,  0, IDLE_RES},
			'{1, '{16'd1, 8'd255, 1'b1}, CMD_WRITE, 8'hC3, 0, 1, 18, 0, IDLE_RES},
			'{0, NO_CFG, CMD_WAIT,  8'h00, 0, 1, 6,  0, IDLE_RES},
			'{0, NO_CFG, CMD_START, 8'h00, 0, 1, 3,  0, IDLE_RES},
			'{0, NO_CFG, CMD_STOP,  8'h00, 0, 1, 3,  0, IDLE_RES},
			'{1, '{16'd2, 8'd2, 1'b0}, CMD_WAIT, 8'h00, 0, 1, 12, 0, IDLE_RES}
		};

		phase_cfg = '{
			'{16'd1, 8'd0, 1'b0},
			'{16'd2, 8'd3, 1'b1},
			'{16'd1, 8'd255, 1'b0},
			'{16'd0, 8'd1, 1'b1},
			'{16'd3, 8'd20, 1'b0},
			'{16'd1, 8'd250, 1'b1},
			'{16'd2, 8'd5, 1'b0}
		};

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_TICK;
		req_ch.data_byte <= '0;
		req_ch.send_nack <= 1'b0;
		req_ch.sda_in <= 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_cfg)
				apply_cfg(dir_tab[i].cfg);
			it.req_type = dir_tab[i].req;
			it.data_byte = dir_tab[i].data;
			it.send_nack = dir_tab[i].nack;
			it.sda_in = dir_tab[i].sda;
			offer_request(it, dir_tab[i].typed, dir_tab[i].want);
			repeat (dir_tab[i].ticks)
				offer_tick(dir_tab[i].sda);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == N_PHASES - 1) begin
				apply_cfg('{16'hFFFF, 8'd250, 1'b0});
				it.req_type = CMD_STOP;
				it.data_byte = BYTE_W'($urandom);
				it.send_nack = 1'($urandom);
				it.sda_in = 1'($urandom);
				offer_request(it, 1'b0, IDLE_RES);
				repeat (4)
					offer_tick(1'($urandom));
				idling_on = 1'b0;
			end
			apply_cfg(phase_cfg[p]);
			run_random(p);
		end

		drain_levels();
		repeat (8) @(posedge clk);
		$display("Covered %0d requests, %0d results, %0d register settings, %0d ack timeouts",
			n_req, n_res, n_cfg, n_timeouts);
		$display("Commands run: start %0d stop %0d write %0d read %0d wait %0d",
			cmd_cnt[CMD_START], cmd_cnt[CMD_STOP], cmd_cnt[CMD_WRITE], cmd_cnt[CMD_READ],
			cmd_cnt[CMD_WAIT]);
		if (n_err == 0 && bus_levels_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", n_err);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
